// File: sv/insertion_sorter_macros.svh
// Assertion macros shared by the insertion sorter checkers.
// Each macro expands to one labeled concurrent assertion on clk and rst_n.
`ifndef INSERTION_SORTER_MACROS_SVH
`define INSERTION_SORTER_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define ISORT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("insertion sorter check failed");

// Consequent must hold in the same cycle as the antecedent.
`define ISORT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("insertion sorter check failed");

`endif

// File: sv/isort_pkg.sv
// Shared types and constants for the insertion sorter.
// No dependencies; used by isort_cell and insertion_sorter.
package isort_pkg;

  localparam int DEPTH       = 64;
  localparam int VALUE_WIDTH = 16;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  // Command broadcast to every cell in a cycle.
  typedef struct packed {
    logic insert;  // place the shared value into the ordered row
    logic shift;   // move every entry one cell toward the output
  } cell_ctrl_t;

endpackage

// File: sv/isort_cell.sv
// One cell of the insertion chain: holds one ordered entry and its valid bit.
// Depends on isort_pkg for value_t and cell_ctrl_t.
module isort_cell
  import isort_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  value_t     new_value,
  input  value_t     left_value,
  input  logic       left_valid,
  input  logic       left_greater,
  input  value_t     right_value,
  input  logic       right_valid,
  output value_t     value,
  output logic       valid,
  output logic       greater
);

  value_t value_r, value_nxt;
  logic   valid_r, valid_nxt;
  logic   take;

  // Strictly greater, so a new value lands after any equal keys.
  assign greater = valid_r && (value_r > new_value);

  // The first empty cell also takes part in an insertion.
  assign take = greater || (!valid_r && left_valid);

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctrl.shift) begin
      value_nxt = right_value;
      valid_nxt = right_valid;
    end else if (ctrl.insert && take) begin
      value_nxt = left_greater ? left_value : new_value;
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign value = value_r;
  assign valid = valid_r;

endmodule

// File: sv/insertion_sorter.sv
// Top level of the insertion sorter: a row of isort_cell and the drain control.
// Depends on isort_pkg and isort_cell.
//
// Usage: values arrive on the in_ channel, one per beat, with in_last_flag
// marking the final value of a set. Each accepted value is placed into its
// ordered position by all cells comparing in parallel, so loading runs at
// one beat per cycle while in_stall is low. Equal values keep their arrival
// order. Once the row holds DEPTH values, further values of the set are
// dropped and out_overflow is set on every result of that set.
// After the beat carrying in_last_flag, in_stall goes high and the set drains
// from cell 0, one result per cycle while out_stall is low; the row shifts
// toward the output as each result enters the output register. Once the
// final beat has been accepted and the drain flag registered, the first
// result is loaded into the output register. The set drains through the
// single output port at cell 0. out_end_of_run marks the largest value, and
// in_stall falls as that beat appears in the output register. When the
// receiver stalls, the output register holds its beat and the row waits.
// Synchronous reset empties the row and clears the output valid bit.
module insertion_sorter
  import isort_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  value_t in_value,
  input  logic   in_last_flag,
  output logic   out_valid,
  input  logic   out_stall,
  output value_t out_sorted_value,
  output logic   out_end_of_run,
  output logic   out_overflow
);

  value_t     cell_value   [DEPTH];
  logic       cell_valid   [DEPTH];
  logic       cell_greater [DEPTH];
  cell_ctrl_t ctrl;

  logic   in_acc, full, load;
  logic   draining_r, draining_nxt;
  logic   dropped_r, dropped_nxt;
  logic   run_ovf_r, run_ovf_nxt;
  logic   out_valid_r, out_valid_nxt;
  value_t out_value_r, out_value_nxt;
  logic   out_end_r, out_end_nxt;
  logic   out_ovf_r, out_ovf_nxt;

  assign in_stall = draining_r;
  assign in_acc   = in_valid && !draining_r;
  assign full     = cell_valid[DEPTH-1];
  assign load     = draining_r && (!out_valid_r || !out_stall);

  assign ctrl.insert = in_acc && !full;
  assign ctrl.shift  = load;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    value_t l_value, r_value;
    logic   l_valid, l_greater, r_valid;

    if (i == 0) begin : g_head
      assign l_value   = in_value;
      assign l_valid   = 1'b1;
      assign l_greater = 1'b0;
    end else begin : g_mid
      assign l_value   = cell_value[i-1];
      assign l_valid   = cell_valid[i-1];
      assign l_greater = cell_greater[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_value = cell_value[i];
      assign r_valid = 1'b0;
    end else begin : g_body
      assign r_value = cell_value[i+1];
      assign r_valid = cell_valid[i+1];
    end

    isort_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl         (ctrl),
      .new_value    (in_value),
      .left_value   (l_value),
      .left_valid   (l_valid),
      .left_greater (l_greater),
      .right_value  (r_value),
      .right_valid  (r_valid),
      .value        (cell_value[i]),
      .valid        (cell_valid[i]),
      .greater      (cell_greater[i])
    );
  end

  always_comb begin
    draining_nxt  = draining_r;
    dropped_nxt   = dropped_r;
    run_ovf_nxt   = run_ovf_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_end_nxt   = out_end_r;
    out_ovf_nxt   = out_ovf_r;

    if (in_acc) begin
      if (in_last_flag) begin
        draining_nxt = 1'b1;
        run_ovf_nxt  = dropped_r || full;
        dropped_nxt  = 1'b0;
      end else if (full) begin
        dropped_nxt = 1'b1;
      end
    end

    if (load) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = cell_value[0];
      out_end_nxt   = !cell_valid[1];
      out_ovf_nxt   = run_ovf_r;
      // Cell 1 empty means cell 0 holds the last entry of the set.
      if (!cell_valid[1]) begin
        draining_nxt = 1'b0;
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_end_r   <= out_end_nxt;
    out_ovf_r   <= out_ovf_nxt;
    run_ovf_r   <= run_ovf_nxt;
    if (!rst_n) begin
      draining_r  <= 1'b0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      draining_r  <= draining_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_end_of_run   = out_end_r;
  assign out_overflow     = out_ovf_r;

endmodule

// File: sv/isort_checker.sv
// Port-level checks for insertion_sorter, attached by the bind at the end.
// Depends on isort_pkg and insertion_sorter_macros.svh.
`include "insertion_sorter_macros.svh"

module isort_checker
  import isort_pkg::*;
(
  input logic   clk,
  input logic   rst_n,
  input logic   in_valid,
  input logic   in_stall,
  input logic   in_last_flag,
  input logic   out_valid,
  input logic   out_stall,
  input value_t out_sorted_value,
  input logic   out_end_of_run,
  input logic   out_overflow
);

  // A stalled result beat holds its payload.
  `ISORT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_sorted_value))
  `ISORT_ASSERT_NEXT(a_out_hold_flags, out_valid && out_stall, $stable({out_end_of_run, out_overflow}))

  // The final beat of a set closes the input while the set drains.
  `ISORT_ASSERT_NEXT(a_last_stalls, in_valid && !in_stall && in_last_flag, in_stall)

  // The input reopens only as the end-of-run beat enters the output register.
  `ISORT_ASSERT_NOW(a_reopen_at_end, $fell(in_stall) && $past(rst_n), out_valid && out_end_of_run)

  // Nothing is produced before a set has been closed.
  `ISORT_ASSERT_NOW(a_out_needs_drain, $rose(out_valid) && $past(rst_n), $past(in_stall))

endmodule

bind insertion_sorter isort_checker u_isort_checker (.*);
